FILE: rtl/core/lsbgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbgc_pkg
// Shared types and constants for the LCD shadow buffer and glyph cache.
// ----------------------------------------------------------------------------
package lsbgc_pkg;

   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [5:0] COLUMN_COUNT_RESET = 6'd16;
   localparam logic [2:0] LINE_COUNT_RESET = 3'd2;
   localparam logic [31:0] USE_SEQ_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_CHAR  = 2'd0,
      MODE_GLYPH = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_COLUMN_COUNT = 1'b0,
      CSR_LINE_COUNT   = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHAR,
      ST_MATCH,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_PICK,
      ST_PLACE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_target;
      logic do_char;
      logic scan_start;
      logic scan_step;
      logic pick_step;
      logic place;
      logic clear_start;
      logic clear_step;
      logic out_zero;
      logic out_clear;
   } cmd_type;

   typedef struct packed {
      logic       in_area;
      mode_type   mode;
      logic       found;
      logic       scan_last;
      logic       pick_last;
      logic       clear_last;
   } status_type;

endpackage

FILE: rtl/core/lsbgc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbgc_req_if / lsbgc_rsp_if / lsbgc_csr_if
// Valid/ready channels of the glyph cache unit.
// ----------------------------------------------------------------------------
interface lsbgc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [1:0]  line;
   logic [5:0]  column;
   logic [7:0]  char_code;
   logic [63:0] glyph_bits;
   modport source (output valid, mode, line, column, char_code, glyph_bits, input ready);
   modport sink   (input valid, mode, line, column, char_code, glyph_bits, output ready);
endinterface

interface lsbgc_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_cell;
   logic [1:0]  cell_line;
   logic [5:0]  cell_column;
   logic [7:0]  cell_code;
   logic        define_glyph;
   logic [2:0]  define_slot;
   logic [63:0] defined_bits;
   logic        clear_display;
   modport source (output valid, write_cell, cell_line, cell_column, cell_code,
                   define_glyph, define_slot, defined_bits, clear_display, input ready);
   modport sink   (input valid, write_cell, cell_line, cell_column, cell_code,
                   define_glyph, define_slot, defined_bits, clear_display, output ready);
endinterface

interface lsbgc_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [7:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/lsbgc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbgc_ctrl
// Sequencer for character writes, glyph placement scans and clears.
// ----------------------------------------------------------------------------
module lsbgc_ctrl
   import lsbgc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_target = 1'b1;
            case (status.mode)
               MODE_CHAR: begin
                  state_in = status.in_area ? ST_CHAR : ST_DONE;
                  cmd.out_zero = 1'b1;
               end
               MODE_GLYPH: begin
                  state_in = status.in_area ? ST_MATCH : ST_DONE;
                  cmd.out_zero = 1'b1;
               end
               MODE_CLEAR: begin
                  cmd.clear_start = 1'b1;
                  cmd.out_clear = 1'b1;
                  state_in = ST_CLEAR;
               end
               default: begin
                  cmd.out_zero = 1'b1;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CHAR: begin
            cmd.do_char = 1'b1;
            state_in = ST_DONE;
         end
         ST_MATCH: begin
            if (status.found) begin
               state_in = ST_PLACE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_SCAN_LAST;
            end
         end
         ST_SCAN_LAST: begin
            cmd.scan_step = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick_step = 1'b1;
            if (status.pick_last) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_load_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.rd_target) else $error("load not followed by read");
`endif

endmodule

FILE: rtl/core/lsbgc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbgc_datapath
// Shadow memory, glyph slot registers, usage counters and result register.
// ----------------------------------------------------------------------------
module lsbgc_datapath
   import lsbgc_pkg::*;
#(
   parameter int MAX_LINES   = 4,
   parameter int MAX_COLUMNS = 40,
   parameter int GLYPH_SLOTS = 8
)(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_mode,
   input  logic [1:0]  req_line,
   input  logic [5:0]  req_column,
   input  logic [7:0]  req_char_code,
   input  logic [63:0] req_glyph_bits,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output logic        rsp_write_cell,
   output logic [1:0]  rsp_cell_line,
   output logic [5:0]  rsp_cell_column,
   output logic [7:0]  rsp_cell_code,
   output logic        rsp_define_glyph,
   output logic [2:0]  rsp_define_slot,
   output logic [63:0] rsp_defined_bits,
   output logic        rsp_clear_display
);

   localparam int LB    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CB    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int DEPTH = MAX_LINES * MAX_COLUMNS;
   localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SB    = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
   localparam int UB    = $clog2(DEPTH + 1);

   logic [5:0] column_count_ff;
   logic [2:0] line_count_ff;
   logic [7:0] shadow_mem [DEPTH];
   logic [7:0] rd_data_ff;

   mode_type    mode_ff;
   logic [1:0]  line_ff;
   logic [5:0]  column_ff;
   logic [7:0]  code_ff;
   logic [63:0] bits_ff;

   logic [63:0] slot_bits_ff [GLYPH_SLOTS];
   logic [31:0] last_use_ff  [GLYPH_SLOTS];
   logic [GLYPH_SLOTS-1:0] valid_ff;
   logic [31:0] use_seq_ff;
   logic [UB-1:0] usage_ff [GLYPH_SLOTS];

   logic [SB-1:0] slot_ff;
   logic          found_ff;
   logic [SB-1:0] pick_ff;
   logic [SB-1:0] best_ff;
   logic          have_zero_ff;

   logic [LB-1:0] sl_ff;
   logic [CB-1:0] sc_ff;
   logic          sv_ff;
   logic          sdone_ff;
   logic [AB-1:0] caddr_ff;
   logic          clearing_ff;

   logic [3:0] act_lines;
   logic [6:0] act_cols;
   logic       in_area;
   logic [AB-1:0] tgt_addr;
   logic [AB-1:0] scan_addr;

   always_comb begin
      act_lines = (32'(line_count_ff) > MAX_LINES) ? 4'(MAX_LINES) : {1'b0, line_count_ff};
      act_cols  = (32'(column_count_ff) > MAX_COLUMNS) ? 7'(MAX_COLUMNS)
                                                       : {1'b0, column_count_ff};
      in_area   = ({2'b0, line_ff} < act_lines) && ({1'b0, column_ff} < act_cols);
      tgt_addr  = AB'(32'(line_ff) * MAX_COLUMNS + 32'(column_ff));
      scan_addr = AB'(32'(sl_ff) * MAX_COLUMNS + 32'(sc_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         line_count_ff   <= LINE_COUNT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_COLUMN_COUNT) begin
            column_count_ff <= csr_data[5:0];
         end else begin
            line_count_ff <= csr_data[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= mode_type'(req_mode);
         line_ff   <= req_line;
         column_ff <= req_column;
         code_ff   <= req_char_code;
         bits_ff   <= req_glyph_bits;
      end
   end

   // shadow memory: one write and one read port
   logic          mem_we;
   logic [AB-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AB-1:0] mem_raddr;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = tgt_addr;
      mem_wdata = code_ff;
      if (cmd.clear_step || clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = caddr_ff;
         mem_wdata = SPACE_CODE;
      end else if (cmd.do_char) begin
         mem_we = (rd_data_ff != code_ff);
      end else if (cmd.place) begin
         mem_we    = 1'b1;
         mem_wdata = 8'(slot_ff);
      end
      mem_raddr = cmd.rd_target ? tgt_addr : scan_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= shadow_mem[mem_raddr];
   end

   // clear sweep counter, also run once after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         caddr_ff    <= '0;
         clearing_ff <= 1'b1;
      end else if (cmd.clear_start) begin
         caddr_ff <= '0;
      end else if (cmd.clear_step || clearing_ff) begin
         if (32'(caddr_ff) == DEPTH - 1) begin
            caddr_ff    <= '0;
            clearing_ff <= 1'b0;
         end else begin
            caddr_ff <= caddr_ff + AB'(1);
         end
      end
   end

   // scan address counter
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         sl_ff    <= '0;
         sc_ff    <= '0;
         sv_ff    <= 1'b0;
         sdone_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         sv_ff <= !sdone_ff;
         if (32'(sc_ff) + 1 >= 32'(act_cols)) begin
            sc_ff <= '0;
            if (32'(sl_ff) + 1 >= 32'(act_lines)) begin
               sdone_ff <= 1'b1;
            end else begin
               sl_ff <= sl_ff + LB'(1);
            end
         end else begin
            sc_ff <= sc_ff + CB'(1);
         end
      end
   end

   // usage counters
   always_ff @(posedge clock) begin
      for (int i = 0; i < GLYPH_SLOTS; i++) begin
         if (cmd.scan_start) begin
            usage_ff[i] <= '0;
         end else if (cmd.scan_step && sv_ff && (32'(rd_data_ff) == i)) begin
            usage_ff[i] <= usage_ff[i] + UB'(1);
         end
      end
   end

   // match search over valid slots
   logic          match_hit;
   logic [SB-1:0] match_idx;
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = GLYPH_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && slot_bits_ff[i] == bits_ff) begin
            match_hit = 1'b1;
            match_idx = SB'(i);
         end
      end
   end

   logic pick_better;
   assign pick_better = (usage_ff[pick_ff] < usage_ff[best_ff]) ||
                        (usage_ff[pick_ff] == usage_ff[best_ff] &&
                         last_use_ff[pick_ff] < last_use_ff[best_ff]);

   always_ff @(posedge clock) begin
      if (cmd.rd_target) begin
         found_ff     <= 1'b0;
         pick_ff      <= '0;
         best_ff      <= '0;
         have_zero_ff <= 1'b0;
      end else if (status.mode == MODE_GLYPH && !cmd.scan_step && !cmd.pick_step &&
                   !cmd.place && !found_ff && !cmd.scan_start && match_hit) begin
         found_ff <= 1'b1;
         slot_ff  <= match_idx;
      end else if (cmd.pick_step && !have_zero_ff) begin
         if (usage_ff[pick_ff] == '0) begin
            have_zero_ff <= 1'b1;
            slot_ff      <= pick_ff;
         end else if (pick_ff == '0 || pick_better) begin
            best_ff <= pick_ff;
            slot_ff <= pick_ff;
         end
         pick_ff <= pick_ff + SB'(1);
      end else if (cmd.pick_step) begin
         pick_ff <= pick_ff + SB'(1);
      end
   end

   logic [31:0] seq_next;
   assign seq_next = (use_seq_ff != USE_SEQ_MAX) ? use_seq_ff + 32'd1 : use_seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         use_seq_ff <= '0;
         for (int i = 0; i < GLYPH_SLOTS; i++) begin
            last_use_ff[i] <= '0;
         end
      end else if (cmd.place) begin
         use_seq_ff           <= seq_next;
         last_use_ff[slot_ff] <= seq_next;
         if (!found_ff) begin
            valid_ff[slot_ff]     <= 1'b1;
            slot_bits_ff[slot_ff] <= bits_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_zero || cmd.out_clear) begin
         rsp_write_cell    <= 1'b0;
         rsp_cell_line     <= '0;
         rsp_cell_column   <= '0;
         rsp_cell_code     <= '0;
         rsp_define_glyph  <= 1'b0;
         rsp_define_slot   <= '0;
         rsp_defined_bits  <= '0;
         rsp_clear_display <= cmd.out_clear;
      end else if (cmd.do_char && rd_data_ff != code_ff) begin
         rsp_write_cell  <= 1'b1;
         rsp_cell_line   <= line_ff;
         rsp_cell_column <= column_ff;
         rsp_cell_code   <= code_ff;
      end else if (cmd.place) begin
         rsp_write_cell  <= 1'b1;
         rsp_cell_line   <= line_ff;
         rsp_cell_column <= column_ff;
         rsp_cell_code   <= 8'(slot_ff);
         if (!found_ff) begin
            rsp_define_glyph <= 1'b1;
            rsp_define_slot  <= 3'(slot_ff);
            rsp_defined_bits <= bits_ff;
         end
      end
   end

   always_comb begin
      status.in_area    = in_area;
      status.mode       = mode_ff;
      status.found      = found_ff || match_hit;
      status.scan_last  = sdone_ff;
      status.pick_last  = (32'(pick_ff) == GLYPH_SLOTS - 1) || have_zero_ff ||
                          (usage_ff[pick_ff] == '0);
      status.clear_last = (32'(caddr_ff) == DEPTH - 1);
   end

`ifndef NO_ASSERTIONS
   a_place_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> valid_ff[$past(slot_ff)]) else $error("placed slot not valid");
   a_seq_mono: assert property (@(posedge clock) disable iff (reset)
      use_seq_ff >= $past(use_seq_ff)) else $error("use counter went back");
   a_char_out: assert property (@(posedge clock) disable iff (reset)
      cmd.do_char |=> (rsp_write_cell == 1'b0 || rsp_cell_code == $past(code_ff)))
      else $error("char result code mismatch");
`endif

endmodule

FILE: rtl/core/lcd_shadow_buffer_glyph_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_shadow_buffer_glyph_cache_unit
// Shadow buffer of a character LCD with a custom glyph slot cache.
// ----------------------------------------------------------------------------
// channel  direction  payload
// req      in         mode, line, column, char_code, glyph_bits
// rsp      out        write_cell .. clear_display, one per transaction
// csr      in         index (0 column_count, 1 line_count), data
//
// Character write: load, read and write states, then the response wait. Glyph
// placement: on a slot hit, match and place; else a scan of the active area
// through the shadow memory read port and a victim slot pick come before the
// place. Clear: all MAX_LINES*MAX_COLUMNS cells, one cell a cycle. After reset a
// clearing pass runs and req is held off until it is through.
// ----------------------------------------------------------------------------
module lcd_shadow_buffer_glyph_cache_unit
   import lsbgc_pkg::*;
#(
   parameter int MAX_LINES   = 4,
   parameter int MAX_COLUMNS = 40,
   parameter int GLYPH_SLOTS = 8
)(
   input logic        clock,
   input logic        reset,
   lsbgc_req_if.sink  req,
   lsbgc_rsp_if.source rsp,
   lsbgc_csr_if.sink  csr
);

   localparam int IB = $clog2(MAX_LINES * MAX_COLUMNS + 1);

   cmd_type    cmd;
   status_type status;
   logic       ctrl_ready;
   logic       busy_ff;
   logic [IB-1:0] init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         init_ff <= '0;
      end else if (busy_ff) begin
         init_ff <= init_ff + IB'(1);
         if (32'(init_ff) == MAX_LINES * MAX_COLUMNS) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign req.ready = ctrl_ready && !busy_ff;
   assign csr.ready = 1'b1;

   lsbgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid && !busy_ff),
      .req_ready (ctrl_ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsbgc_datapath #(
      .MAX_LINES   (MAX_LINES),
      .MAX_COLUMNS (MAX_COLUMNS),
      .GLYPH_SLOTS (GLYPH_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req.mode),
      .req_line          (req.line),
      .req_column        (req.column),
      .req_char_code     (req.char_code),
      .req_glyph_bits    (req.glyph_bits),
      .csr_we            (csr.valid),
      .csr_index         (csr.index[0]),
      .csr_data          (csr.data),
      .rsp_write_cell    (rsp.write_cell),
      .rsp_cell_line     (rsp.cell_line),
      .rsp_cell_column   (rsp.cell_column),
      .rsp_cell_code     (rsp.cell_code),
      .rsp_define_glyph  (rsp.define_glyph),
      .rsp_define_slot   (rsp.define_slot),
      .rsp_defined_bits  (rsp.defined_bits),
      .rsp_clear_display (rsp.clear_display)
   );

endmodule

FILE: tb/lcd_shadow_buffer_glyph_cache_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_shadow_buffer_glyph_cache_unit_test
// Drives character, glyph, clear and unused-mode transactions through the
// unit under several display sizes. A built-in shadow and slot cache predict
// every response, and each response is compared field by field.
// ----------------------------------------------------------------------------
module lcd_shadow_buffer_glyph_cache_unit_test;
   import lsbgc_pkg::*;

   localparam int LINES_MAX = 4;
   localparam int COLS_MAX = 40;
   localparam int SLOTS = 8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  line;
      logic [5:0]  column;
      logic [7:0]  char_code;
      logic [63:0] glyph_bits;
   } lcd_cmd_t;

   typedef struct packed {
      logic        write_cell;
      logic [1:0]  cell_line;
      logic [5:0]  cell_column;
      logic [7:0]  cell_code;
      logic        define_glyph;
      logic [2:0]  define_slot;
      logic [63:0] defined_bits;
      logic        clear_display;
   } lcd_update_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsbgc_req_if req ();
   lsbgc_rsp_if rsp ();
   lsbgc_csr_if csr ();

   lcd_shadow_buffer_glyph_cache_unit i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #6 clock = ~clock;

   lcd_cmd_t    pending_cmds[$];
   lcd_update_t expected_updates[$];
   int          errors = 0;
   int          sent_count = 0;
   bit          hold_rsp = 1'b0;
   bit          calm = 1'b0;
   bit          req_fire = 1'b0;

   logic [7:0]  shadow[LINES_MAX][COLS_MAX];
   logic [63:0] slot_bits[SLOTS];
   logic [SLOTS-1:0] slot_ok;
   logic [31:0] slot_stamp[SLOTS];
   logic [31:0] stamp_seq;
   logic [5:0]  cols_reg;
   logic [2:0]  lines_reg;

   function automatic void shadow_fill();
      for (int r = 0; r < LINES_MAX; r++)
         for (int c = 0; c < COLS_MAX; c++) shadow[r][c] = SPACE_CODE;
   endfunction

   function automatic int pick_victim_slot(int nl, int nc);
      int usage[SLOTS];
      int best;
      best = 0;
      for (int i = 0; i < SLOTS; i++) usage[i] = 0;
      for (int r = 0; r < nl; r++)
         for (int c = 0; c < nc; c++)
            if (shadow[r][c] < SLOTS) usage[shadow[r][c]]++;
      for (int i = 0; i < SLOTS; i++) begin
         if (usage[i] == 0) return i;
         if (i == 0 || usage[i] < usage[best] ||
             (usage[i] == usage[best] && slot_stamp[i] < slot_stamp[best])) best = i;
      end
      return best;
   endfunction

   function automatic lcd_update_t predict_update(lcd_cmd_t cmd);
      lcd_update_t u;
      int nl, nc, slot;
      bit hit, area;
      u = '0;
      nl = (lines_reg > LINES_MAX) ? LINES_MAX : lines_reg;
      nc = (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
      area = (cmd.line < nl) && (cmd.column < nc);
      case (mode_type'(cmd.mode))
         MODE_CHAR: begin
            if (area && shadow[cmd.line][cmd.column] != cmd.char_code) begin
               shadow[cmd.line][cmd.column] = cmd.char_code;
               u.write_cell = 1'b1;
               u.cell_line = cmd.line;
               u.cell_column = cmd.column;
               u.cell_code = cmd.char_code;
            end
         end
         MODE_GLYPH: begin
            if (area) begin
               hit = 1'b0;
               slot = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (!hit && slot_ok[i] && slot_bits[i] == cmd.glyph_bits) begin
                     hit = 1'b1;
                     slot = i;
                  end
               if (!hit) begin
                  slot = pick_victim_slot(nl, nc);
                  slot_bits[slot] = cmd.glyph_bits;
                  slot_ok[slot] = 1'b1;
                  u.define_glyph = 1'b1;
                  u.define_slot = 3'(slot);
                  u.defined_bits = cmd.glyph_bits;
               end
               if (stamp_seq != USE_SEQ_MAX) stamp_seq++;
               slot_stamp[slot] = stamp_seq;
               shadow[cmd.line][cmd.column] = 8'(slot);
               u.write_cell = 1'b1;
               u.cell_line = cmd.line;
               u.cell_column = cmd.column;
               u.cell_code = 8'(slot);
            end
         end
         MODE_CLEAR: begin
            shadow_fill();
            u.clear_display = 1'b1;
         end
         default: ;
      endcase
      return u;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !req_fire) begin
      end else if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
         req.valid <= 1'b1;
         {req.mode, req.line, req.column, req.char_code, req.glyph_bits} <= pending_cmds.pop_front();
      end else begin
         req.valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_fire = req.valid && req.ready;
      if (!reset && req.valid && req.ready) begin
         expected_updates.push_back(predict_update(
            {req.mode, req.line, req.column, req.char_code, req.glyph_bits}));
         sent_count++;
      end
   end

   // monitor
   always @(negedge clock)
      rsp.ready <= !reset && !hold_rsp && (calm || $urandom_range(99) >= 20);

   always @(posedge clock) begin
      lcd_update_t got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.write_cell, rsp.cell_line, rsp.cell_column, rsp.cell_code,
                rsp.define_glyph, rsp.define_slot, rsp.defined_bits, rsp.clear_display};
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected update %h", $time, got);
            errors++;
         end else begin
            want = expected_updates.pop_front();
            if (got.write_cell !== want.write_cell || got.cell_line !== want.cell_line ||
                got.cell_column !== want.cell_column || got.cell_code !== want.cell_code ||
                got.define_glyph !== want.define_glyph ||
                got.define_slot !== want.define_slot ||
                got.defined_bits !== want.defined_bits ||
                got.clear_display !== want.clear_display) begin
               $display("%0t: expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || req.valid || expected_updates.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      if (idx == CSR_COLUMN_COUNT) cols_reg = value[5:0];
      else lines_reg = value[2:0];
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic logic [63:0] glyph_from_pool();
      logic [63:0] pool[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1F11_1F11_1F00_0000,
                               64'h0A0A_0A0A_0A0A_0A0A};
      if ($urandom_range(3) == 0) return {$urandom, $urandom};
      return pool[$urandom_range(3)] ^ 64'($urandom_range(9));
   endfunction

   function automatic lcd_cmd_t random_cmd();
      lcd_cmd_t cmd;
      int sel;
      sel = $urandom_range(99);
      cmd.mode = (sel < 45) ? MODE_CHAR : (sel < 90) ? MODE_GLYPH :
                 (sel < 95) ? MODE_CLEAR : MODE_NONE;
      cmd.line = 2'($urandom_range(3));
      cmd.column = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) :
                   6'($urandom_range((lines_reg == 0) ? 39 : ((cols_reg > 0) ? cols_reg : 1)));
      if (cmd.column > 63) cmd.column = 63;
      cmd.char_code = ($urandom_range(3) == 0) ? 8'($urandom_range(9)) :
                      8'($urandom_range(255));
      cmd.glyph_bits = glyph_from_pool();
      return cmd;
   endfunction

   task automatic push_cmd(mode_type m, int l, int c, int code, logic [63:0] bits);
      pending_cmds.push_back({m, 2'(l), 6'(c), 8'(code), bits});
   endtask

   initial begin
      int cfg_cols[5] = '{16, 40, 1, 63, 20};
      int cfg_lines[5] = '{2, 4, 1, 7, 0};
      req.valid = 1'b0;
      req.mode = '0;
      req.line = '0;
      req.column = '0;
      req.char_code = '0;
      req.glyph_bits = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = CSR_COLUMN_COUNT;
      csr.data = '0;
      shadow_fill();
      slot_bits = '{default: '0};
      slot_ok = '0;
      slot_stamp = '{default: '0};
      stamp_seq = '0;
      cols_reg = COLUMN_COUNT_RESET;
      lines_reg = LINE_COUNT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_cmd(MODE_CHAR, 0, 0, 8'hFF, 0);
      push_cmd(MODE_CHAR, 0, 0, 8'hFF, 0);
      push_cmd(MODE_CHAR, 1, 15, 8'h00, 0);
      push_cmd(MODE_CHAR, 1, 16, 8'h41, 0);
      push_cmd(MODE_CHAR, 3, 63, 8'h41, 0);
      push_cmd(MODE_CHAR, 0, 5, SPACE_CODE, 0);
      for (int i = 0; i < 9; i++)
         push_cmd(MODE_GLYPH, i % 2, i, 0, 64'h1111 * (i + 1));
      push_cmd(MODE_GLYPH, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_cmd(MODE_GLYPH, 1, 3, 0, 64'h1111 * 3);
      push_cmd(MODE_GLYPH, 2, 0, 0, 64'h0);
      push_cmd(MODE_NONE, 3, 63, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      push_cmd(MODE_CLEAR, 0, 0, 0, 0);
      push_cmd(MODE_GLYPH, 0, 1, 0, 64'h0);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         csr_write(CSR_COLUMN_COUNT, 8'(cfg_cols[phase]));
         csr_write(CSR_LINE_COUNT, 8'(cfg_lines[phase]));
         calm = (phase == 2);
         for (int n = 0; n < 200; n++) pending_cmds.push_back(random_cmd());
         if (phase == 1) begin
            hold_rsp = 1'b1;
            fork
               begin
                  repeat (3000) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         drain();
         if (phase == 3) begin
            csr_write(CSR_LINE_COUNT, 8'd4);
            for (int n = 0; n < 60; n++) pending_cmds.push_back(random_cmd());
            drain();
         end
      end
      calm = 1'b0;
      csr_write(CSR_COLUMN_COUNT, 8'd8);
      csr_write(CSR_LINE_COUNT, 8'd3);
      for (int n = 0; n < 40; n++) pending_cmds.push_back(random_cmd());
      drain();

      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #60ms;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/lsbgc_pkg.sv
rtl/core/lsbgc_if.sv
rtl/core/lsbgc_ctrl.sv
rtl/core/lsbgc_datapath.sv
rtl/core/lcd_shadow_buffer_glyph_cache_unit.sv
tb/lcd_shadow_buffer_glyph_cache_unit_test.sv
